### design/ssqr_pkg.sv
// Shared types and constants for the sun sensor quaternion rotation pipeline.
package ssqr_pkg;

  localparam int DW    = 16;
  localparam int PW    = 33;
  localparam int RW    = 51;
  localparam int NW    = 33;
  localparam int SQ_SH = 28;
  localparam int VW    = NW + SQ_SH;
  localparam int ROOTW = 31;
  localparam int NUMW  = 51;
  localparam int QW    = 17;
  localparam int LANES = 3;

  localparam logic signed [DW-1:0] THRESH_RESET = 16'sd573;
  localparam logic [QW-1:0]        SAT_POS      = 17'd32767;
  localparam logic [QW-1:0]        SAT_NEG      = 17'd32768;
  localparam logic signed [DW-1:0] OUT_MAX      = 16'sh7fff;
  localparam logic signed [DW-1:0] OUT_MIN      = 16'sh8000;

  typedef struct packed {
    logic signed [DW-1:0] quat_w;
    logic signed [DW-1:0] quat_x;
    logic signed [DW-1:0] quat_y;
    logic signed [DW-1:0] quat_z;
    logic signed [DW-1:0] sun_in_x;
    logic signed [DW-1:0] sun_in_y;
    logic signed [DW-1:0] sun_in_z;
  } ssqr_in_t;

  typedef struct packed {
    logic signed [DW-1:0] body_x;
    logic signed [DW-1:0] body_y;
    logic signed [DW-1:0] body_z;
    logic                 sun_seen;
  } ssqr_out_t;

  typedef struct packed {
    logic [LANES-1:0][RW-1:0] r;
    logic [NW-1:0]            n;
  } ssqr_rot_t;

  typedef struct packed {
    logic [LANES-1:0][RW-1:0] r;
    logic [VW-1:0]            rem;
    logic [ROOTW-1:0]         root;
  } ssqr_sq_t;

  typedef struct packed {
    logic            neg;
    logic            ovf;
    logic [NUMW-1:0] rem;
    logic [QW-1:0]   quo;
  } ssqr_lane_t;

  typedef struct packed {
    ssqr_lane_t [LANES-1:0] lane;
    logic [ROOTW-1:0]       den;
  } ssqr_dv_t;

endpackage

### design/sun_sensor_quaternion_rotate.sv
// Sun sensor body-frame rotation: top level with handshake and threshold register.
// Stages in order: multiply, the 31-stage square root chain, divide set-up, the 17-stage
// divide chain, then the output register. Throughput: one transaction per cycle while the
// output is not stalled; every stage is a register stage sharing one advance enable.
// Reset (synchronous, active high) clears all valid bits and loads the threshold
// with 573; payload registers are not reset.
module sun_sensor_quaternion_rotate import ssqr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ssqr_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ssqr_out_t            out_data,
  input  logic                 threshold_we,
  input  logic signed [DW-1:0] threshold_wdata
);

  logic                 adv;
  logic signed [DW-1:0] thresh;
  logic                 m_vld, s_vld;
  ssqr_rot_t            m_data;
  ssqr_sq_t             s_data;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (threshold_we) begin
      thresh <= threshold_wdata;
    end
  end

  ssqr_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (in_valid && in_ready),
    .din     (in_data),
    .out_vld (m_vld),
    .dout    (m_data)
  );

  ssqr_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (m_vld),
    .din     (m_data),
    .out_vld (s_vld),
    .dout    (s_data)
  );

  ssqr_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (s_vld),
    .din     (s_data),
    .thresh  (thresh),
    .out_vld (out_valid),
    .dout    (out_data)
  );

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_seen_above_thresh: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sun_seen |-> out_data.body_z > thresh)
    else $error("sun_seen set with body_z at or below threshold");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

### design/ssqr_mult.sv
// Quaternion sandwich product q*(0,s)*conj(q) and norm squared, four stages.
module ssqr_mult import ssqr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      in_vld,
  input  ssqr_in_t  din,
  output logic      out_vld,
  output ssqr_rot_t dout
);

  logic [3:0] vld;
  logic signed [31:0] m1 [12];
  logic signed [31:0] sq [4];
  ssqr_in_t q1, q2;
  logic signed [PW-1:0] p [4];
  logic [NW-1:0] n2, n3, n4;
  logic signed [48:0] m3 [12];
  logic signed [RW-1:0] r4 [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_vld};
    end
  end

  // products of q and s
  always_ff @(posedge clk) begin
    if (adv) begin
      q1     <= din;
      m1[0]  <= din.quat_x * din.sun_in_x;
      m1[1]  <= din.quat_y * din.sun_in_y;
      m1[2]  <= din.quat_z * din.sun_in_z;
      m1[3]  <= din.quat_w * din.sun_in_x;
      m1[4]  <= din.quat_y * din.sun_in_z;
      m1[5]  <= din.quat_z * din.sun_in_y;
      m1[6]  <= din.quat_w * din.sun_in_y;
      m1[7]  <= din.quat_z * din.sun_in_x;
      m1[8]  <= din.quat_x * din.sun_in_z;
      m1[9]  <= din.quat_w * din.sun_in_z;
      m1[10] <= din.quat_x * din.sun_in_y;
      m1[11] <= din.quat_y * din.sun_in_x;
      sq[0]  <= din.quat_w * din.quat_w;
      sq[1]  <= din.quat_x * din.quat_x;
      sq[2]  <= din.quat_y * din.quat_y;
      sq[3]  <= din.quat_z * din.quat_z;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q2   <= q1;
      p[0] <= -PW'(m1[0]) - PW'(m1[1]) - PW'(m1[2]);
      p[1] <= PW'(m1[3]) + PW'(m1[4]) - PW'(m1[5]);
      p[2] <= PW'(m1[6]) + PW'(m1[7]) - PW'(m1[8]);
      p[3] <= PW'(m1[9]) + PW'(m1[10]) - PW'(m1[11]);
      n2   <= NW'($unsigned(sq[0])) + NW'($unsigned(sq[1]))
            + NW'($unsigned(sq[2])) + NW'($unsigned(sq[3]));
    end
  end

  // products with the conjugate
  always_ff @(posedge clk) begin
    if (adv) begin
      n3     <= n2;
      m3[0]  <= p[0] * q2.quat_x;
      m3[1]  <= p[1] * q2.quat_w;
      m3[2]  <= p[2] * q2.quat_z;
      m3[3]  <= p[3] * q2.quat_y;
      m3[4]  <= p[0] * q2.quat_y;
      m3[5]  <= p[2] * q2.quat_w;
      m3[6]  <= p[3] * q2.quat_x;
      m3[7]  <= p[1] * q2.quat_z;
      m3[8]  <= p[0] * q2.quat_z;
      m3[9]  <= p[3] * q2.quat_w;
      m3[10] <= p[1] * q2.quat_y;
      m3[11] <= p[2] * q2.quat_x;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n4    <= n3;
      r4[0] <= -RW'(m3[0]) + RW'(m3[1]) - RW'(m3[2]) + RW'(m3[3]);
      r4[1] <= -RW'(m3[4]) + RW'(m3[5]) - RW'(m3[6]) + RW'(m3[7]);
      r4[2] <= -RW'(m3[8]) + RW'(m3[9]) - RW'(m3[10]) + RW'(m3[11]);
    end
  end

  assign out_vld   = vld[3];
  assign dout.n    = n4;
  assign dout.r[0] = r4[0];
  assign dout.r[1] = r4[1];
  assign dout.r[2] = r4[2];

endmodule

### design/ssqr_sqrt.sv
// Pipelined integer square root of the scaled norm, one root bit per stage.
module ssqr_sqrt import ssqr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      in_vld,
  input  ssqr_rot_t din,
  output logic      out_vld,
  output ssqr_sq_t  dout
);

  ssqr_sq_t st_in;
  ssqr_sq_t st [ROOTW];
  logic [ROOTW-1:0] vld;

  assign st_in.r    = din.r;
  assign st_in.rem  = {din.n, {SQ_SH{1'b0}}};
  assign st_in.root = '0;

  for (genvar i = 0; i < ROOTW; i++) begin : g_stage
    localparam int B = ROOTW - 1 - i;
    ssqr_sq_t       prv;
    logic           prv_vld;
    logic [VW+1:0]  trial;
    logic [VW+1:0]  rem_ext;

    if (i == 0) begin : g_first
      assign prv     = st_in;
      assign prv_vld = in_vld;
    end else begin : g_next
      assign prv     = st[i-1];
      assign prv_vld = vld[i-1];
    end

    assign rem_ext = (VW+2)'(prv.rem);
    assign trial   = ((VW+2)'(prv.root) << (B + 1)) + ((VW+2)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= prv_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[i].r <= prv.r;
        if (rem_ext >= trial) begin
          st[i].rem  <= VW'(rem_ext - trial);
          st[i].root <= prv.root | (ROOTW'(1) << B);
        end else begin
          st[i].rem  <= prv.rem;
          st[i].root <= prv.root;
        end
      end
    end
  end

  assign out_vld = vld[ROOTW-1];
  assign dout    = st[ROOTW-1];

endmodule

### design/ssqr_div.sv
// Rounded divide by the root, saturation and visibility test, output register last.
module ssqr_div import ssqr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  ssqr_sq_t             din,
  input  logic signed [DW-1:0] thresh,
  output logic                 out_vld,
  output ssqr_out_t            dout
);

  ssqr_dv_t d0, d1;
  logic     v0, v1;
  ssqr_dv_t bs [QW];
  logic [QW-1:0] bv;
  ssqr_dv_t last;
  logic signed [DW-1:0] res [LANES];
  logic [QW-1:0] nq [LANES];
  logic      ov;
  ssqr_out_t ores;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      ov <= 1'b0;
    end else if (adv) begin
      v0 <= in_vld;
      v1 <= v0;
      ov <= bv[QW-1];
    end
  end

  // magnitude plus half divisor for round to nearest
  always_ff @(posedge clk) begin
    if (adv) begin
      d0.den <= din.root;
      for (int l = 0; l < LANES; l++) begin
        d0.lane[l].neg <= din.r[l][RW-1];
        d0.lane[l].ovf <= 1'b0;
        d0.lane[l].quo <= '0;
        d0.lane[l].rem <= (din.r[l][RW-1] ? NUMW'(-$signed(din.r[l])) : NUMW'(din.r[l]))
                        + NUMW'(din.root >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1.den <= d0.den;
      for (int l = 0; l < LANES; l++) begin
        d1.lane[l].neg <= d0.lane[l].neg;
        d1.lane[l].rem <= d0.lane[l].rem;
        d1.lane[l].quo <= d0.lane[l].quo;
        d1.lane[l].ovf <= d0.lane[l].rem >= (NUMW'(d0.den) << QW);
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    localparam int K = QW - 1 - j;
    ssqr_dv_t      prv;
    logic          prv_vld;
    logic [NUMW-1:0] sub;

    if (j == 0) begin : g_first
      assign prv     = d1;
      assign prv_vld = v1;
    end else begin : g_next
      assign prv     = bs[j-1];
      assign prv_vld = bv[j-1];
    end

    assign sub = NUMW'(prv.den) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        bv[j] <= 1'b0;
      end else if (adv) begin
        bv[j] <= prv_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        bs[j].den <= prv.den;
        for (int l = 0; l < LANES; l++) begin
          bs[j].lane[l].neg <= prv.lane[l].neg;
          bs[j].lane[l].ovf <= prv.lane[l].ovf;
          if (prv.lane[l].rem >= sub) begin
            bs[j].lane[l].rem <= prv.lane[l].rem - sub;
            bs[j].lane[l].quo <= prv.lane[l].quo | (QW'(1) << K);
          end else begin
            bs[j].lane[l].rem <= prv.lane[l].rem;
            bs[j].lane[l].quo <= prv.lane[l].quo;
          end
        end
      end
    end
  end

  assign last = bs[QW-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      nq[l] = -last.lane[l].quo;
      if (last.den == '0) begin
        res[l] = '0;
      end else if (last.lane[l].neg) begin
        res[l] = (last.lane[l].ovf || last.lane[l].quo > SAT_NEG) ? OUT_MIN
                                                                   : $signed(nq[l][DW-1:0]);
      end else begin
        res[l] = (last.lane[l].ovf || last.lane[l].quo > SAT_POS) ? OUT_MAX
                                                                   : $signed(last.lane[l].quo[DW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ores.body_x   <= res[0];
      ores.body_y   <= res[1];
      ores.body_z   <= res[2];
      ores.sun_seen <= (last.den != '0) && (res[2] > thresh);
    end
  end

  assign out_vld = ov;
  assign dout    = ores;

endmodule

### tb/sv/tb_sun_sensor_quaternion_rotate.sv
// Testbench for the sun sensor quaternion rotation block: predicted body vectors and flags.
`timescale 1ns / 1ps
module tb_sun_sensor_quaternion_rotate;
  import ssqr_pkg::*;

  localparam int WDOG_LIMIT = 5000;
  localparam int DRAIN      = 70;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  ssqr_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  ssqr_out_t out_data;
  logic      threshold_we;
  logic signed [DW-1:0] threshold_wdata;

  sun_sensor_quaternion_rotate uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .threshold_we(threshold_we), .threshold_wdata(threshold_wdata)
  );

  logic signed [DW-1:0] thresh_model;
  ssqr_out_t            body_q[$];
  int                   errors;
  int                   send_idle_pct;
  int                   recv_stall_pct;
  int                   holdoff_cycles;
  int                   quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] round_sat(input longint num,
                                                     input longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    if (num < 0) return (q > 32768) ? OUT_MIN : DW'(-longint'(q));
    return (q > 32767) ? OUT_MAX : DW'(q);
  endfunction

  function automatic ssqr_out_t rotate_sun(input ssqr_in_t d);
    longint w, x, y, z, sx, sy, sz, p0, p1, p2, p3, r1, r2, r3;
    longint unsigned n, den;
    ssqr_out_t o;
    w = d.quat_w; x = d.quat_x; y = d.quat_y; z = d.quat_z;
    sx = d.sun_in_x; sy = d.sun_in_y; sz = d.sun_in_z;
    o = '0;
    n = w * w + x * x + y * y + z * z;
    if (n != 0) begin
      p0 = -x * sx - y * sy - z * sz;
      p1 = w * sx + y * sz - z * sy;
      p2 = w * sy + z * sx - x * sz;
      p3 = w * sz + x * sy - y * sx;
      r1 = -p0 * x + p1 * w - p2 * z + p3 * y;
      r2 = -p0 * y + p2 * w - p3 * x + p1 * z;
      r3 = -p0 * z + p3 * w - p1 * y + p2 * x;
      den = int_sqrt(n << 28);
      o.body_x = round_sat(r1, den);
      o.body_y = round_sat(r2, den);
      o.body_z = round_sat(r3, den);
      o.sun_seen = (o.body_z > thresh_model);
    end
    return o;
  endfunction

  // receiver side: random stalls plus optional long hold-off
  always @(negedge clk) begin
    if (holdoff_cycles > 0) begin
      out_ready <= 1'b0;
      holdoff_cycles <= holdoff_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    ssqr_out_t exp_o;
    if (!rst && out_valid && out_ready) begin
      if (body_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
      end else begin
        exp_o = body_q.pop_front();
        if (out_data.body_x !== exp_o.body_x) begin
          errors++;
          $display("%0t: body_x expected %0d actual %0d", $time, exp_o.body_x, out_data.body_x);
        end
        if (out_data.body_y !== exp_o.body_y) begin
          errors++;
          $display("%0t: body_y expected %0d actual %0d", $time, exp_o.body_y, out_data.body_y);
        end
        if (out_data.body_z !== exp_o.body_z) begin
          errors++;
          $display("%0t: body_z expected %0d actual %0d", $time, exp_o.body_z, out_data.body_z);
        end
        if (out_data.sun_seen !== exp_o.sun_seen) begin
          errors++;
          $display("%0t: sun_seen expected %0b actual %0b", $time, exp_o.sun_seen,
                   out_data.sun_seen);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(input ssqr_in_t d);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_data  = d;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    body_q.push_back(rotate_sun(d));
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (body_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_threshold(input logic signed [DW-1:0] v);
    go_idle();
    @(negedge clk);
    threshold_we    = 1'b1;
    threshold_wdata = v;
    thresh_model    = v;
    @(negedge clk);
    threshold_we    = 1'b0;
  endtask

  function automatic logic signed [DW-1:0] rand_field();
    logic signed [DW-1:0] v;
    v = DW'($urandom);
    return v >>> $urandom_range(3);
  endfunction

  function automatic ssqr_in_t rand_item();
    ssqr_in_t d;
    d.quat_w = rand_field(); d.quat_x = rand_field();
    d.quat_y = rand_field(); d.quat_z = rand_field();
    d.sun_in_x = rand_field(); d.sun_in_y = rand_field(); d.sun_in_z = rand_field();
    if ($urandom_range(19) == 0) begin
      d.quat_w = '0; d.quat_x = '0; d.quat_y = '0; d.quat_z = '0;
    end
    return d;
  endfunction

  function automatic ssqr_in_t make_item(input int w, x, y, z, sx, sy, sz);
    ssqr_in_t d;
    d.quat_w = DW'(w); d.quat_x = DW'(x); d.quat_y = DW'(y); d.quat_z = DW'(z);
    d.sun_in_x = DW'(sx); d.sun_in_y = DW'(sy); d.sun_in_z = DW'(sz);
    return d;
  endfunction

  task automatic test_directed();
    send_item(make_item(0, 0, 0, 0, 16384, 16384, 16384));
    send_item(make_item(16384, 0, 0, 0, 0, 0, 16384));
    send_item(make_item(16384, 0, 0, 0, 0, 0, 573));
    send_item(make_item(16384, 0, 0, 0, 0, 0, 574));
    send_item(make_item(16384, 0, 0, 0, 0, 0, -16384));
    send_item(make_item(0, 16384, 0, 0, 16384, -16384, 16384));
    send_item(make_item(0, 0, 16384, 0, 16384, 0, 0));
    send_item(make_item(0, 0, 0, 16384, 0, 16384, 0));
    send_item(make_item(11585, 11585, 0, 0, 0, 16384, 0));
    send_item(make_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_item(make_item(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_item(make_item(32767, -32768, 32767, -32768, 32767, -32768, 32767));
    send_item(make_item(1, 0, 0, 0, 32767, 32767, 32767));
    send_item(make_item(0, 0, 0, -1, -32768, 0, 1));
    send_item(make_item(8192, 8192, 8192, 8192, 16384, 0, 0));
    send_item(make_item(0, 0, 0, 0, -32768, -32768, -32768));
  endtask

  task automatic test_thresholds();
    logic signed [DW-1:0] th[4];
    th = '{-16384, 16384, 0, 573};
    foreach (th[i]) begin
      write_threshold(th[i]);
      repeat (40) send_item(rand_item());
      send_item(make_item(16384, 0, 0, 0, 0, 0, th[i]));
      send_item(make_item(16384, 0, 0, 0, 0, 0, th[i] + 1));
    end
    write_threshold(DW'($urandom_range(32768) - 16384));
    repeat (40) send_item(rand_item());
  endtask

  task automatic test_random_phases();
    int idle_pct[4];
    int stall_pct[4];
    idle_pct  = '{0, 76, 0, 38};
    stall_pct = '{0, 0, 76, 38};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      repeat (200) send_item(rand_item());
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    holdoff_cycles = 400;
    repeat (150) send_item(rand_item());
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    threshold_we    = 1'b0;
    threshold_wdata = '0;
    thresh_model    = THRESH_RESET;
    errors          = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    holdoff_cycles  = 0;
    quiet_cycles    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_phases();
    test_backpressure();
    test_thresholds();
    go_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
design/ssqr_pkg.sv
design/ssqr_mult.sv
design/ssqr_sqrt.sv
design/ssqr_div.sv
design/sun_sensor_quaternion_rotate.sv
tb/sv/tb_sun_sensor_quaternion_rotate.sv
